>>> hdl/binary_frame_builder_fletcher8_defines.svh
// Assertion macros for the frame builder.
// Used by the top level only; empty under SYNTHESIS.
`ifndef BINARY_FRAME_BUILDER_FLETCHER8_DEFINES_SVH
`define BINARY_FRAME_BUILDER_FLETCHER8_DEFINES_SVH
`ifndef SYNTHESIS
`define BFB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BFB_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define BFB_ASSERT(label, clk, rst_n, prop, msg)
`define BFB_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

>>> hdl/bfb_pkg.sv
// Shared types and constants of the frame builder.
// No dependencies.
package bfb_pkg;

    localparam int DATA_W    = 8;
    localparam int LEN_W     = 16;
    localparam int CFG_IDX_W = 8;
    localparam int QDEPTH    = 4;
    localparam int QAW       = 2;
    localparam int QCW       = 3;
    localparam int STEP_W    = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 8'd1;
    localparam logic [DATA_W-1:0]    SYNC_FIRST_RST  = 8'd181;
    localparam logic [DATA_W-1:0]    SYNC_SECOND_RST = 8'd98;

    // byte positions inside a header job
    localparam logic [STEP_W-1:0] H_SYNC1  = 3'd0;
    localparam logic [STEP_W-1:0] H_SYNC2  = 3'd1;
    localparam logic [STEP_W-1:0] H_CLASS  = 3'd2;
    localparam logic [STEP_W-1:0] H_MSGID  = 3'd3;
    localparam logic [STEP_W-1:0] H_LEN_LO = 3'd4;
    localparam logic [STEP_W-1:0] H_LEN_HI = 3'd5;
    localparam logic [STEP_W-1:0] H_CK_A   = 3'd6;
    localparam logic [STEP_W-1:0] H_CK_B   = 3'd7;
    // byte positions inside a payload job
    localparam logic [STEP_W-1:0] D_BYTE   = 3'd0;
    localparam logic [STEP_W-1:0] D_CK_A   = 3'd1;
    localparam logic [STEP_W-1:0] D_CK_B   = 3'd2;

    typedef enum logic [4:0] {
        K_HDR      = 5'b00001,
        K_HDR_END  = 5'b00010,
        K_DATA     = 5'b00100,
        K_DATA_END = 5'b01000,
        K_ERR      = 5'b10000
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [DATA_W-1:0] b0;    // class or payload byte
        logic [DATA_W-1:0] b1;
        logic [DATA_W-1:0] len_lo;
        logic [DATA_W-1:0] len_hi;
        logic [DATA_W-1:0] ck_a;
        logic [DATA_W-1:0] ck_b;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef struct packed {
        logic [DATA_W-1:0] sync_first;
        logic [DATA_W-1:0] sync_second;
    } t_cfg;

endpackage

>>> hdl/bfb_if.sv
// Channel interfaces of the frame builder: input items, output bytes, config writes.
// Depends on bfb_pkg.
interface bfb_in_if;
    logic                      valid;
    logic                      ready;
    logic                      command;
    logic [bfb_pkg::DATA_W-1:0] class_id;
    logic [bfb_pkg::DATA_W-1:0] message_id;
    logic [bfb_pkg::LEN_W-1:0]  payload_length;
    logic [bfb_pkg::DATA_W-1:0] data_byte;
    modport source (output valid, command, class_id, message_id, payload_length,
                    data_byte, input ready);
    modport sink (input valid, command, class_id, message_id, payload_length,
                  data_byte, output ready);
endinterface

interface bfb_out_if;
    logic                      valid;
    logic                      ready;
    logic [bfb_pkg::DATA_W-1:0] out_byte;
    logic                      frame_end;
    logic                      error;
    modport source (output valid, out_byte, frame_end, error, input ready);
    modport sink (input valid, out_byte, frame_end, error, output ready);
endinterface

interface bfb_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [bfb_pkg::CFG_IDX_W-1:0] index;
    logic [bfb_pkg::DATA_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/binary_frame_builder_fletcher8.sv
// Top level of the binary frame builder with 8-bit Fletcher checksum.
// Depends on bfb_pkg, bfb_if, bfb_front, bfb_fifo, bfb_back and the defines header.
//
// Usage:
//   i_in  : one item per beat. command 0 opens a frame (class, id, length),
//           command 1 carries one payload byte.
//   o_out : one frame byte per beat; frame_end marks checksum byte B, error
//           marks a payload byte that came with no frame open.
//   i_cfg : register 0 = first sync byte (reset 0xB5), 1 = second (reset 0x62).
//           Always ready; write only while the block is idle.
// Timing: a payload byte yields one output byte (three on the last byte), a
//   header six (eight when the length is zero). Sustained rate is one output
//   byte per cycle while o_out is ready and jobs are queued, set by the back end's
//   single output register. Items pass the job queue, then the output register.
//   A four-entry job queue lets input stay ready while output is stalled;
//   input ready drops only when the queue is full.
// Reset: synchronous, active low; clears checksums, open frame and queue.
`include "binary_frame_builder_fletcher8_defines.svh"
module binary_frame_builder_fletcher8 (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bfb_in_if.sink    i_in,
    bfb_cfg_if.sink   i_cfg,
    bfb_out_if.source o_out
);
    import bfb_pkg::*;

    t_cfg   r_cfg;
    t_job   w_job;
    t_job   w_head;
    t_qstat w_stat;
    logic   w_push;
    logic   w_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first  <= SYNC_FIRST_RST;
            r_cfg.sync_second <= SYNC_SECOND_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_SYNC_FIRST:  r_cfg.sync_first  <= i_cfg.data;
                REG_SYNC_SECOND: r_cfg.sync_second <= i_cfg.data;
                default:         r_cfg <= r_cfg;
            endcase
        end
    end

    bfb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (w_stat.full),
        .o_push   (w_push),
        .o_job    (w_job)
    );

    bfb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_stat)
    );

    bfb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_head  (w_head),
        .i_stat  (w_stat),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

    `BFB_NEVER(a_q_full_empty, i_clk, i_rst_n, w_stat.full && w_stat.empty, "queue full and empty")
    `BFB_NEVER(a_push_full, i_clk, i_rst_n, w_push && w_stat.full, "push into full queue")
    `BFB_NEVER(a_pop_empty, i_clk, i_rst_n, w_pop && w_stat.empty, "pop from empty queue")
    `BFB_NEVER(a_end_err, i_clk, i_rst_n, o_out.valid && o_out.frame_end && o_out.error, "end beat flagged error")

endmodule

>>> hdl/bfb_front.sv
// Front end: accepts items, keeps frame state and checksums, pushes one job per item.
// Depends on bfb_pkg and bfb_if.
module bfb_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bfb_in_if.sink        i_in,
    input  logic          i_q_full,
    output logic          o_push,
    output bfb_pkg::t_job o_job
);
    import bfb_pkg::*;

    logic [DATA_W-1:0] r_sum_a, n_sum_a;
    logic [DATA_W-1:0] r_sum_b, n_sum_b;
    logic [LEN_W-1:0]  r_left, n_left;
    logic              r_open, n_open;
    logic [DATA_W-1:0] a1, a2, a3, a4, b1, b2, b3, b4;
    logic [DATA_W-1:0] pa, pb;
    logic [DATA_W-1:0] len_lo, len_hi;
    logic              accept;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;
    assign o_push     = accept;
    assign len_lo     = i_in.payload_length[7:0];
    assign len_hi     = i_in.payload_length[15:8];

    // header checksum starts from zero over class, id, length
    assign a1 = i_in.class_id;
    assign b1 = i_in.class_id;
    assign a2 = a1 + i_in.message_id;
    assign b2 = b1 + a2;
    assign a3 = a2 + len_lo;
    assign b3 = b2 + a3;
    assign a4 = a3 + len_hi;
    assign b4 = b3 + a4;
    assign pa = r_sum_a + i_in.data_byte;
    assign pb = r_sum_b + pa;

    always_comb begin
        n_sum_a      = r_sum_a;
        n_sum_b      = r_sum_b;
        n_left       = r_left;
        n_open       = r_open;
        o_job.kind   = K_ERR;
        o_job.b0     = i_in.data_byte;
        o_job.b1     = i_in.message_id;
        o_job.len_lo = len_lo;
        o_job.len_hi = len_hi;
        o_job.ck_a   = pa;
        o_job.ck_b   = pb;
        if (!i_in.command) begin
            o_job.b0   = i_in.class_id;
            o_job.ck_a = a4;
            o_job.ck_b = b4;
            n_sum_a    = a4;
            n_sum_b    = b4;
            n_left     = i_in.payload_length;
            n_open     = (i_in.payload_length != '0);
            o_job.kind = (i_in.payload_length == '0) ? K_HDR_END : K_HDR;
        end else if (r_open) begin
            n_sum_a = pa;
            n_sum_b = pb;
            if (r_left == 16'd1) begin
                o_job.kind = K_DATA_END;
                n_left     = '0;
                n_open     = 1'b0;
            end else begin
                o_job.kind = K_DATA;
                n_left     = r_left - 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_a <= '0;
            r_sum_b <= '0;
            r_left  <= '0;
            r_open  <= 1'b0;
        end else if (accept) begin
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
            r_left  <= n_left;
            r_open  <= n_open;
        end
    end

endmodule

>>> hdl/bfb_fifo.sv
// Short job queue between front and back end.
// Depends on bfb_pkg.
module bfb_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bfb_pkg::t_job   i_job,
    input  logic            i_pop,
    output bfb_pkg::t_job   o_head,
    output bfb_pkg::t_qstat o_stat
);
    import bfb_pkg::*;

    t_job             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr, r_rd;
    logic [QCW-1:0]   r_cnt;
    logic             do_push, do_pop;

    assign o_stat.full  = (r_cnt == QCW'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + QCW'(1);
                2'b01:   r_cnt <= r_cnt - QCW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> hdl/bfb_back.sv
// Back end: expands the head job into output bytes, one per beat, through an output register.
// Depends on bfb_pkg and bfb_if.
module bfb_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bfb_pkg::t_cfg   i_cfg,
    input  bfb_pkg::t_job   i_head,
    input  bfb_pkg::t_qstat i_stat,
    output logic            o_pop,
    bfb_out_if.source       o_out
);
    import bfb_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic              r_valid;
    logic [DATA_W-1:0] r_byte, n_byte;
    logic              r_end, n_end;
    logic              r_err, n_err;
    logic              last;
    logic              load;

    assign load = !i_stat.empty && (!r_valid || o_out.ready);
    assign o_pop = load && last;

    always_comb begin
        n_byte = '0;
        n_end  = 1'b0;
        n_err  = 1'b0;
        last   = 1'b1;
        case (i_head.kind)
            K_HDR, K_HDR_END: begin
                case (r_step)
                    H_SYNC1:  n_byte = i_cfg.sync_first;
                    H_SYNC2:  n_byte = i_cfg.sync_second;
                    H_CLASS:  n_byte = i_head.b0;
                    H_MSGID:  n_byte = i_head.b1;
                    H_LEN_LO: n_byte = i_head.len_lo;
                    H_LEN_HI: n_byte = i_head.len_hi;
                    H_CK_A:   n_byte = i_head.ck_a;
                    H_CK_B: begin
                        n_byte = i_head.ck_b;
                        n_end  = 1'b1;
                    end
                    default:  n_byte = '0;
                endcase
                last = (i_head.kind == K_HDR) ? (r_step == H_LEN_HI) : (r_step == H_CK_B);
            end
            K_DATA, K_DATA_END: begin
                case (r_step)
                    D_BYTE: n_byte = i_head.b0;
                    D_CK_A: n_byte = i_head.ck_a;
                    D_CK_B: begin
                        n_byte = i_head.ck_b;
                        n_end  = 1'b1;
                    end
                    default: n_byte = '0;
                endcase
                last = (i_head.kind == K_DATA) ? (r_step == D_BYTE) : (r_step == D_CK_B);
            end
            K_ERR: begin
                n_err = 1'b1;
            end
            default: begin
                n_byte = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= n_byte;
            r_end  <= n_end;
            r_err  <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_step  <= last ? '0 : r_step + STEP_W'(1);
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.out_byte  = r_byte;
    assign o_out.frame_end = r_end;
    assign o_out.error     = r_err;

endmodule
